[src/ckblit_pkg.sv]
// ============================================================================
// ckblit_pkg
// Shared types and constants for the color-keyed sprite blitter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ckblit_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int MAX_SPRITE_DIM    = 255;

    localparam logic [7:0] KEY_RESET = 8'hE3;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam int COORD_W = 11;
    localparam int POS_W   = 13;
    localparam int ADDR_W  = 17;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         data;
        logic               last;
    } blit_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[src/ckblit_front.sv]
// ============================================================================
// ckblit_front
// Accepts start and pixel items, tracks the sprite position and classifies
// each pixel into a framebuffer operation for the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ckblit_front #(
    parameter int SCREEN_WIDTH  = ckblit_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ckblit_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        func,
    input  wire logic signed [11:0]          origin_x,
    input  wire logic signed [11:0]          origin_y,
    input  wire logic [7:0]                  sprite_width,
    input  wire logic [7:0]                  rows_to_draw,
    input  wire logic                        flip_vertical,
    input  wire logic [7:0]                  pixel_value,
    input  wire logic                        cfg_write,
    input  wire logic [7:0]                  cfg_data,
    input  wire ckblit_pkg::queue_status_t   q_status,
    output logic                             push,
    output ckblit_pkg::blit_op_t             push_op
);

    localparam logic signed [ckblit_pkg::POS_W-1:0] SW_S =
        ckblit_pkg::POS_W'(SCREEN_WIDTH);
    localparam logic signed [ckblit_pkg::POS_W-1:0] SH_S =
        ckblit_pkg::POS_W'(SCREEN_HEIGHT);
    localparam logic [11:0] MAX_DIM = 12'(ckblit_pkg::MAX_SPRITE_DIM);

    logic [7:0]                             key_reg;
    logic signed [ckblit_pkg::POS_W-1:0]    ox_reg;
    logic signed [ckblit_pkg::POS_W-1:0]    base_y_reg;
    logic                                   flip_reg;
    logic [7:0]                             width_reg;
    logic [7:0]                             rows_reg;
    logic [7:0]                             col_reg;
    logic [7:0]                             row_reg;
    logic                                   active_reg;

    logic [7:0]                             width_sat;
    logic [7:0]                             rows_sat;
    logic signed [ckblit_pkg::POS_W-1:0]    base_y_next;
    logic signed [ckblit_pkg::POS_W-1:0]    sx;
    logic signed [ckblit_pkg::POS_W-1:0]    sy;
    logic                                   on_screen;
    logic                                   row_end;
    logic                                   draw_end;
    logic                                   accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    always_comb
    begin
        width_sat = (12'(sprite_width) > MAX_DIM) ? MAX_DIM[7:0] : sprite_width;
        rows_sat  = (12'(rows_to_draw) > MAX_DIM) ? MAX_DIM[7:0] : rows_to_draw;
        base_y_next = ckblit_pkg::POS_W'(origin_y);
        if (flip_vertical)
        begin
            base_y_next = base_y_next + $signed({5'd0, rows_sat})
                          - ckblit_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        sx = ox_reg + $signed({5'd0, col_reg});
        if (flip_reg)
        begin
            sy = base_y_reg - $signed({5'd0, row_reg});
        end
        else
        begin
            sy = base_y_reg + $signed({5'd0, row_reg});
        end
        on_screen = !sx[ckblit_pkg::POS_W-1] && (sx < SW_S) &&
                    !sy[ckblit_pkg::POS_W-1] && (sy < SH_S);
        row_end  = (9'(col_reg) + 9'd1) >= 9'(width_reg);
        draw_end = row_end && ((9'(row_reg) + 9'd1) >= 9'(rows_reg));
    end

    always_comb
    begin
        push_op = '0;
        if (func == ckblit_pkg::FUNC_PIXEL && active_reg)
        begin
            push_op.last = draw_end;
            if (on_screen && pixel_value != key_reg)
            begin
                push_op.we   = 1'b1;
                push_op.col  = sx[ckblit_pkg::COORD_W-1:0];
                push_op.row  = sy[ckblit_pkg::COORD_W-1:0];
                push_op.data = pixel_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= ckblit_pkg::KEY_RESET;
        end
        else if (cfg_write)
        begin
            key_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg     <= '0;
            base_y_reg <= '0;
            flip_reg   <= 1'b0;
            width_reg  <= '0;
            rows_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (func == ckblit_pkg::FUNC_START)
            begin
                ox_reg     <= ckblit_pkg::POS_W'(origin_x);
                base_y_reg <= base_y_next;
                flip_reg   <= flip_vertical;
                width_reg  <= width_sat;
                rows_reg   <= rows_sat;
                col_reg    <= '0;
                row_reg    <= '0;
                active_reg <= (width_sat != 8'd0) && (rows_sat != 8'd0);
            end
            else if (active_reg)
            begin
                if (draw_end)
                begin
                    col_reg    <= '0;
                    row_reg    <= '0;
                    active_reg <= 1'b0;
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 8'd1;
                end
                else
                begin
                    col_reg <= col_reg + 8'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/ckblit_queue.sv]
// ============================================================================
// ckblit_queue
// Short FIFO of classified operations between the front and back ends.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ckblit_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire ckblit_pkg::blit_op_t       push_op,
    input  wire logic                       pop,
    output ckblit_pkg::blit_op_t            pop_op,
    output ckblit_pkg::queue_status_t       status
);

    localparam int DEPTH = ckblit_pkg::QUEUE_DEPTH;
    localparam int PW    = ckblit_pkg::QPTR_W;
    localparam int CW    = ckblit_pkg::QCNT_W;

    ckblit_pkg::blit_op_t entry_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_op       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[src/ckblit_back.sv]
// ============================================================================
// ckblit_back
// Turns queued operations into framebuffer writes with a linear address and
// holds each result in an output register until it is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ckblit_back #(
    parameter int SCREEN_WIDTH = ckblit_pkg::SCREEN_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ckblit_pkg::queue_status_t   q_status,
    input  wire ckblit_pkg::blit_op_t        pop_op,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             write_enable,
    output logic [ckblit_pkg::ADDR_W-1:0]    fb_address,
    output logic [7:0]                       write_data,
    output logic                             last_pixel
);

    localparam int PROD_W = 2 * ckblit_pkg::COORD_W;

    logic                          valid_reg;
    logic                          we_reg;
    logic [ckblit_pkg::ADDR_W-1:0] addr_reg;
    logic [7:0]                    data_reg;
    logic                          last_reg;

    logic [PROD_W-1:0]             prod;
    logic [ckblit_pkg::ADDR_W-1:0] addr_next;

    assign pop = !q_status.empty && (!valid_reg || out_ready);

    always_comb
    begin
        prod      = PROD_W'(pop_op.row) * PROD_W'(SCREEN_WIDTH);
        addr_next = prod[ckblit_pkg::ADDR_W-1:0] + ckblit_pkg::ADDR_W'(pop_op.col);
        if (!pop_op.we)
        begin
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            we_reg   <= pop_op.we;
            addr_reg <= addr_next;
            data_reg <= pop_op.data;
            last_reg <= pop_op.last;
        end
    end

    assign out_valid    = valid_reg;
    assign write_enable = we_reg;
    assign fb_address   = addr_reg;
    assign write_data   = data_reg;
    assign last_pixel   = last_reg;

endmodule

`default_nettype wire

[src/color_key_sprite_blitter_core.sv]
// ============================================================================
// color_key_sprite_blitter_core
// Color-keyed sprite blitter with screen clipping and vertical flip.
// ============================================================================
//
//  Channel   Signals                                  Direction
//  -------   --------------------------------------   ---------
//  in        in_valid/in_ready, func .. pixel_value   into block
//  out       out_valid/out_ready, write_enable ..     out of block
//  cfg       cfg_write, cfg_data (transparent key)    into block
//
//  One result per item; one item per cycle sustained while out_ready stays
//  high; the front-end position counters update once per transfer.
//  Path to result: queue entry, then address multiply into the output register.
//  Reset clears all draw state and loads the key with 0xE3; no clearing pass.
//  Front and back stall independently through a two-entry queue; in_ready
//  drops only when the queue is full.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module color_key_sprite_blitter_core #(
    parameter int SCREEN_WIDTH  = ckblit_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ckblit_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic signed [11:0]           origin_x,
    input  wire logic signed [11:0]           origin_y,
    input  wire logic [7:0]                   sprite_width,
    input  wire logic [7:0]                   rows_to_draw,
    input  wire logic                         flip_vertical,
    input  wire logic [7:0]                   pixel_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              write_enable,
    output logic [ckblit_pkg::ADDR_W-1:0]     fb_address,
    output logic [7:0]                        write_data,
    output logic                              last_pixel,
    input  wire logic                         cfg_write,
    input  wire logic [7:0]                   cfg_data
);

    ckblit_pkg::queue_status_t q_status;
    ckblit_pkg::blit_op_t      push_op;
    ckblit_pkg::blit_op_t      pop_op;
    logic                      push;
    logic                      pop;

    ckblit_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .sprite_width  (sprite_width),
        .rows_to_draw  (rows_to_draw),
        .flip_vertical (flip_vertical),
        .pixel_value   (pixel_value),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .q_status      (q_status),
        .push          (push),
        .push_op       (push_op)
    );

    ckblit_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .status  (q_status)
    );

    ckblit_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_op       (pop_op),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .fb_address   (fb_address),
        .write_data   (write_data),
        .last_pixel   (last_pixel)
    );

`ifndef NO_ASSERTIONS
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (fb_address == '0 && write_data == '0))
        else $error("result without write carries nonzero address or data");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !out_valid) |=> out_valid)
        else $error("queued operation not moved to output register");

    a_start_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && func == ckblit_pkg::FUNC_START) |-> (!push_op.we && !push_op.last))
        else $error("start transfer produced a write or a last flag");
`endif

endmodule

`default_nettype wire
